// ----- design/pspc_pkg.sv -----
// Package for the PID/PT1 speed controller: codes, command/status types,
// fixed-point constants and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package pspc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ACC_W  = 48;
    localparam int unsigned SUM_W  = 50;
    localparam int unsigned MOP_W  = 33;
    localparam int unsigned PROD_W = 66;
    localparam int unsigned MACC_W = 80;
    localparam int unsigned Q_W    = 64;

    localparam logic [MOP_W-1:0] PT1_TIME_FACTOR = 33'd6554;
    localparam logic [MOP_W-1:0] PT1_GAIN        = 33'd65536;
    localparam logic [MOP_W-1:0] SETPOINT_SCALE  = 33'd65536;
    localparam logic [MOP_W-1:0] OUTPUT_SCALE    = 33'd65536;

    // |setpoint| < 0.02 in Q16.16
    localparam logic signed [DATA_W-1:0] SMALL_SETPOINT = 32'sd1310;

    // configuration register indexes
    localparam logic [2:0] REG_CTRL_TYPE = 3'd0;
    localparam logic [2:0] REG_AW_METHOD = 3'd1;
    localparam logic [2:0] REG_KP        = 3'd2;
    localparam logic [2:0] REG_KI        = 3'd3;
    localparam logic [2:0] REG_KD        = 3'd4;
    localparam logic [2:0] REG_TS        = 3'd5;
    localparam logic [2:0] REG_OUT_MIN   = 3'd6;
    localparam logic [2:0] REG_OUT_MAX   = 3'd7;

    localparam logic [2:0] CT_P   = 3'd1;
    localparam logic [2:0] CT_PI  = 3'd2;
    localparam logic [2:0] CT_PID = 3'd3;
    localparam logic [2:0] CT_PT1 = 3'd4;

    localparam logic [1:0] AW_RESET = 2'd2;
    localparam logic [1:0] AW_BACK  = 2'd3;

    localparam logic [1:0] OP_SETPOINT = 2'd0;
    localparam logic [1:0] OP_MEASURE  = 2'd1;
    localparam logic [1:0] OP_RESET    = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_DECODE,
        S_SP_LO, S_SP_HI, S_SP_WR,
        S_START, S_BRANCH,
        S_P_LO, S_P_HI, S_P_WR,
        S_I_LO, S_I_HI, S_I_WR,
        S_KP_LO, S_KP_HI, S_KP_WR,
        S_KI_LO, S_KI_HI, S_KI_WR,
        S_KD_LO, S_KD_HI, S_KD_WR,
        S_SUM, S_AW,
        S_KI2_LO, S_KI2_HI, S_KI2_WR,
        S_SUMR,
        S_X_LO, S_X_HI, S_X_WR,
        S_T_LO, S_T_HI, S_T_WR,
        S_ZERO, S_CLAMP,
        S_O_LO, S_O_HI, S_O_WR,
        S_SMALL
    } t_state;

    typedef enum logic [2:0] {A_E, A_I, A_DE, A_X, A_R, A_V} t_asel;

    typedef enum logic [2:0] {B_KP, B_KI, B_KD, B_TS, B_PG, B_PT, B_OS, B_SS} t_bsel;

    typedef enum logic [4:0] {
        ACT_NONE, ACT_TGT_RAW, ACT_TGT_SCL, ACT_ARM, ACT_START,
        ACT_INTEG, ACT_TP, ACT_TI, ACT_TD, ACT_SUM, ACT_AW, ACT_SUMR,
        ACT_RP, ACT_X, ACT_RPT1, ACT_RZERO, ACT_CLAMP, ACT_OUT, ACT_SMALL
    } t_act;

    typedef struct packed {
        logic  latch;
        logic  mul_en;
        logic  mul_hi;
        t_asel a_sel;
        t_bsel b_sel;
        t_act  act;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] ctype;
        logic       sp_low;
        logic       out_free;
    } t_sts;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [Q_W-1:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sat48(input logic signed [Q_W-1:0] x);
        if (x > 64'sh0000_7FFF_FFFF_FFFF)
            return 48'sh7FFF_FFFF_FFFF;
        else if (x < -64'sh0000_8000_0000_0000)
            return 48'sh8000_0000_0000;
        else
            return x[ACC_W-1:0];
    endfunction

    // controller products limited to +-2^46
    function automatic logic signed [ACC_W-1:0] f_satp(input logic signed [Q_W-1:0] x);
        if (x > 64'sh0000_4000_0000_0000)
            return 48'sh4000_0000_0000;
        else if (x < -64'sh0000_4000_0000_0000)
            return -48'sh4000_0000_0000;
        else
            return x[ACC_W-1:0];
    endfunction

endpackage

// ----- design/pspc_ctrl.sv -----
// Sequencer for the speed controller: walks each transaction through the
// shared multiplier and datapath actions. Depends on pspc_pkg.
`timescale 1ns / 1ps

module pspc_ctrl import pspc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                priority if (i_sts.op == OP_SETPOINT && i_sts.ctype == CT_PT1)
                    n_state = S_SP_LO;
                else if (i_sts.op == OP_MEASURE)
                    n_state = S_START;
                else
                    n_state = S_IDLE;
            end
            S_SP_LO:  n_state = S_SP_HI;
            S_SP_HI:  n_state = S_SP_WR;
            S_SP_WR:  n_state = S_IDLE;
            S_START:  n_state = S_BRANCH;
            S_BRANCH: begin
                priority if (i_sts.sp_low)
                    n_state = S_SMALL;
                else if (i_sts.ctype == CT_P)
                    n_state = S_P_LO;
                else if (i_sts.ctype == CT_PI || i_sts.ctype == CT_PID)
                    n_state = S_I_LO;
                else if (i_sts.ctype == CT_PT1)
                    n_state = S_X_LO;
                else
                    n_state = S_ZERO;
            end
            S_P_LO:   n_state = S_P_HI;
            S_P_HI:   n_state = S_P_WR;
            S_P_WR:   n_state = S_CLAMP;
            S_I_LO:   n_state = S_I_HI;
            S_I_HI:   n_state = S_I_WR;
            S_I_WR:   n_state = S_KP_LO;
            S_KP_LO:  n_state = S_KP_HI;
            S_KP_HI:  n_state = S_KP_WR;
            S_KP_WR:  n_state = S_KI_LO;
            S_KI_LO:  n_state = S_KI_HI;
            S_KI_HI:  n_state = S_KI_WR;
            S_KI_WR:  n_state = (i_sts.ctype == CT_PID) ? S_KD_LO : S_SUM;
            S_KD_LO:  n_state = S_KD_HI;
            S_KD_HI:  n_state = S_KD_WR;
            S_KD_WR:  n_state = S_SUM;
            S_SUM:    n_state = S_AW;
            S_AW:     n_state = S_KI2_LO;
            S_KI2_LO: n_state = S_KI2_HI;
            S_KI2_HI: n_state = S_KI2_WR;
            S_KI2_WR: n_state = S_SUMR;
            S_SUMR:   n_state = S_CLAMP;
            S_X_LO:   n_state = S_X_HI;
            S_X_HI:   n_state = S_X_WR;
            S_X_WR:   n_state = S_T_LO;
            S_T_LO:   n_state = S_T_HI;
            S_T_HI:   n_state = S_T_WR;
            S_T_WR:   n_state = S_CLAMP;
            S_ZERO:   n_state = S_CLAMP;
            S_CLAMP:  n_state = S_O_LO;
            S_O_LO:   n_state = S_O_HI;
            S_O_HI:   n_state = S_O_WR;
            S_O_WR:   if (i_sts.out_free) n_state = S_IDLE;
            S_SMALL:  if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd        = '0;
        o_cmd.a_sel  = A_E;
        o_cmd.b_sel  = B_KP;
        o_cmd.act    = ACT_NONE;
        o_cmd.latch  = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_DECODE: begin
                if (i_sts.op == OP_SETPOINT && i_sts.ctype != CT_PT1)
                    o_cmd.act = ACT_TGT_RAW;
                else if (i_sts.op == OP_RESET)
                    o_cmd.act = ACT_ARM;
            end
            S_SP_LO, S_SP_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_SP_HI);
                o_cmd.a_sel  = A_V;
                o_cmd.b_sel  = B_SS;
            end
            S_SP_WR:  o_cmd.act = ACT_TGT_SCL;
            S_START:  o_cmd.act = ACT_START;
            S_P_LO, S_P_HI, S_KP_LO, S_KP_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_P_HI) || (r_state == S_KP_HI);
                o_cmd.a_sel  = A_E;
                o_cmd.b_sel  = B_KP;
            end
            S_P_WR:   o_cmd.act = ACT_RP;
            S_I_LO, S_I_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_I_HI);
                o_cmd.a_sel  = A_E;
                o_cmd.b_sel  = B_TS;
            end
            S_I_WR:   o_cmd.act = ACT_INTEG;
            S_KP_WR:  o_cmd.act = ACT_TP;
            S_KI_LO, S_KI_HI, S_KI2_LO, S_KI2_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_KI_HI) || (r_state == S_KI2_HI);
                o_cmd.a_sel  = A_I;
                o_cmd.b_sel  = B_KI;
            end
            S_KI_WR, S_KI2_WR: o_cmd.act = ACT_TI;
            S_KD_LO, S_KD_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_KD_HI);
                o_cmd.a_sel  = A_DE;
                o_cmd.b_sel  = B_KD;
            end
            S_KD_WR:  o_cmd.act = ACT_TD;
            S_SUM:    o_cmd.act = ACT_SUM;
            S_AW:     o_cmd.act = ACT_AW;
            S_SUMR:   o_cmd.act = ACT_SUMR;
            S_X_LO, S_X_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_X_HI);
                o_cmd.a_sel  = A_E;
                o_cmd.b_sel  = B_PG;
            end
            S_X_WR:   o_cmd.act = ACT_X;
            S_T_LO, S_T_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_T_HI);
                o_cmd.a_sel  = A_X;
                o_cmd.b_sel  = B_PT;
            end
            S_T_WR:   o_cmd.act = ACT_RPT1;
            S_ZERO:   o_cmd.act = ACT_RZERO;
            S_CLAMP:  o_cmd.act = ACT_CLAMP;
            S_O_LO, S_O_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = (r_state == S_O_HI);
                o_cmd.a_sel  = A_R;
                o_cmd.b_sel  = B_OS;
            end
            S_O_WR:   if (i_sts.out_free) o_cmd.act = ACT_OUT;
            S_SMALL:  if (i_sts.out_free) o_cmd.act = ACT_SMALL;
            default:  o_cmd.act = ACT_NONE;
        endcase
    end

endmodule

// ----- design/pspc_dp.sv -----
// Datapath: configuration and controller state, shared 48x32 multiplier done
// in two 33x33 halves, saturation, clamp and output register. Uses pspc_pkg.
`timescale 1ns / 1ps

module pspc_dp import pspc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic [1:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_sample_value,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_actuator_value
);

    // configuration
    logic [2:0]               r_ctype;
    logic [1:0]               r_aw;
    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_min, r_max;
    logic [DATA_W-2:0]        r_ts;

    // controller state
    logic signed [DATA_W-1:0] r_target, r_pe, r_prev;
    logic signed [ACC_W-1:0]  r_integ;
    logic                     r_clr;

    // transaction payload and working registers
    logic [1:0]               r_op;
    logic signed [DATA_W-1:0] r_v, r_e;
    logic signed [ACC_W-1:0]  r_tp, r_ti, r_td, r_x;
    logic signed [SUM_W-1:0]  r_sum, r_r;
    logic signed [PROD_W-1:0] r_plo;
    logic signed [MACC_W-1:0] r_acc;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out;

    logic signed [ACC_W-1:0]  mul_a;
    logic signed [MOP_W-1:0]  mul_b, mul_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [Q_W-1:0]    q;
    logic signed [ACC_W-1:0]  q_p;
    logic signed [Q_W-1:0]    sum3, aw_hi, aw_lo, sum_w, min_w, max_w, integ_w;
    logic signed [ACC_W-1:0]  aw_hi_s, aw_lo_s;
    logic                     at_max, at_min;

    always_comb begin
        unique case (i_cmd.a_sel)
            A_E:     mul_a = ACC_W'(r_e);
            A_I:     mul_a = r_integ;
            A_DE:    mul_a = ACC_W'(r_e) - ACC_W'(r_pe);
            A_X:     mul_a = r_x;
            A_R:     mul_a = r_r[ACC_W-1:0];
            A_V:     mul_a = ACC_W'(r_v);
            default: mul_a = '0;
        endcase
        unique case (i_cmd.b_sel)
            B_KP:    mul_b = MOP_W'(r_kp);
            B_KI:    mul_b = MOP_W'(r_ki);
            B_KD:    mul_b = MOP_W'(r_kd);
            B_TS:    mul_b = {2'b00, r_ts};
            B_PG:    mul_b = PT1_GAIN;
            B_PT:    mul_b = PT1_TIME_FACTOR;
            B_OS:    mul_b = OUTPUT_SCALE;
            B_SS:    mul_b = SETPOINT_SCALE;
            default: mul_b = '0;
        endcase
        // low half unsigned, high half signed
        mul_op = i_cmd.mul_hi ? MOP_W'(signed'(mul_a[ACC_W-1:DATA_W]))
                              : {1'b0, mul_a[DATA_W-1:0]};
        prod   = mul_op * mul_b;
        q      = r_acc[MACC_W-1:16];
        q_p    = f_satp(q);

        integ_w = Q_W'(r_integ);
        sum3    = Q_W'(r_tp) + Q_W'(r_ti) + Q_W'(r_td);
        sum_w   = Q_W'(r_sum);
        min_w   = Q_W'(r_min);
        max_w   = Q_W'(r_max);
        at_max  = (sum_w >= max_w);
        at_min  = (sum_w <= min_w);
        aw_hi   = integ_w + (max_w - sum_w);
        aw_lo   = integ_w + (min_w - sum_w);
        aw_hi_s = f_sat48(aw_hi);
        aw_lo_s = f_sat48(aw_lo);
    end

    // multiplier halves: second half adds its shifted product to the first
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_hi)
                r_acc <= MACC_W'(r_plo) + (MACC_W'(prod) <<< 32);
            else
                r_plo <= prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctype <= '0;
            r_aw    <= '0;
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_ts    <= 31'd65536;
            r_min   <= -32'sd6553600;
            r_max   <= 32'sd6553600;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CTRL_TYPE: r_ctype <= i_cfg_data[2:0];
                REG_AW_METHOD: r_aw    <= i_cfg_data[1:0];
                REG_KP:        r_kp    <= i_cfg_data;
                REG_KI:        r_ki    <= i_cfg_data;
                REG_KD:        r_kd    <= i_cfg_data;
                REG_TS:        r_ts    <= i_cfg_data[DATA_W-2:0];
                REG_OUT_MIN:   r_min   <= i_cfg_data;
                REG_OUT_MAX:   r_max   <= i_cfg_data;
                default:       r_ctype <= r_ctype;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_operation;
            r_v  <= i_sample_value;
        end
        unique case (i_cmd.act)
            ACT_START: begin
                r_e  <= f_sat32(Q_W'(r_target) - Q_W'(r_v));
                r_td <= '0;
            end
            ACT_TP:    r_tp  <= q_p;
            ACT_TI:    r_ti  <= q_p;
            ACT_TD:    r_td  <= q_p;
            ACT_SUM:   r_sum <= sum3[SUM_W-1:0];
            ACT_SUMR:  r_r   <= sum3[SUM_W-1:0];
            ACT_RP:    r_r   <= SUM_W'(q_p);
            ACT_X:     r_x   <= q_p - ACC_W'(r_prev);
            ACT_RPT1:  r_r   <= SUM_W'(q_p) + SUM_W'(r_prev);
            ACT_RZERO: r_r   <= '0;
            ACT_CLAMP: begin
                if (r_r > SUM_W'(r_max))
                    r_r <= SUM_W'(r_max);
                else if (r_r < SUM_W'(r_min))
                    r_r <= SUM_W'(r_min);
            end
            default:   r_r   <= r_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_integ     <= '0;
            r_pe        <= '0;
            r_prev      <= '0;
            r_clr       <= 1'b0;
        end else begin
            unique case (i_cmd.act)
                ACT_TGT_RAW: r_target <= r_v;
                ACT_TGT_SCL: r_target <= f_sat32(q);
                ACT_ARM:     r_clr    <= 1'b1;
                ACT_START: begin
                    if (r_clr) begin
                        r_integ <= '0;
                        r_pe    <= '0;
                        r_prev  <= '0;
                        r_clr   <= 1'b0;
                    end
                end
                ACT_INTEG:   r_integ <= f_sat48(integ_w + q);
                ACT_AW: begin
                    if (r_aw == AW_RESET) begin
                        if (at_max || at_min)
                            r_integ <= '0;
                    end else if (r_aw == AW_BACK) begin
                        if (at_max)
                            r_integ <= aw_hi_s[ACC_W-1] ? '0 : aw_hi_s;
                        else if (at_min)
                            r_integ <= (aw_lo_s > 0) ? '0 : aw_lo_s;
                    end
                end
                ACT_SUMR: if (r_ctype == CT_PID) r_pe <= r_e;
                ACT_OUT: begin
                    r_prev      <= f_sat32(q);
                    r_out       <= f_sat32(q);
                end
                ACT_SMALL: begin
                    r_integ     <= '0;
                    r_pe        <= '0;
                    r_prev      <= '0;
                    r_out       <= '0;
                end
                default: r_clr <= r_clr;
            endcase
        end
    end

    // a new result may load in the same cycle the old one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.act == ACT_OUT || i_cmd.act == ACT_SMALL) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.ctype    = r_ctype;
    assign o_sts.sp_low   = (r_target >= -SMALL_SETPOINT) && (r_target <= SMALL_SETPOINT);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_actuator_value = r_out;

endmodule

// ----- design/pid_pt1_speed_controller_unit.sv -----
// One transaction in flight; each product is formed by a low and a high pass of the
// single 33x33 multiplier. The output register lets the next item enter while a
// result waits. Synchronous active-low reset restores register defaults and
// clears target, integral, last error, last output and pending clear.
`timescale 1ns / 1ps

module pid_pt1_speed_controller_unit import pspc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_sample_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_actuator_value
);

    t_cmd cmd;
    t_sts sts;

    pspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pspc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_sample_value   (i_sample_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_actuator_value (o_actuator_value)
    );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for pid_pt1_speed_controller_unit: a cycle-free
// predictor of the Q16.16 speed regulator checks every actuator value.
// Depends on pspc_pkg and the design top level.
`timescale 1ns / 1ps

module testbench;
    import pspc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);
    localparam longint PROD_LIM = 64'sd1 <<< 46;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam int STALL_LIMIT = 20000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [2:0]               i_cfg_idx = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_operation = OP_SETPOINT;
    logic signed [DATA_W-1:0] i_sample_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_actuator_value;

    pid_pt1_speed_controller_unit i_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [2:0] ctl_type;
    logic [1:0] aw_mode;
    longint kp, ki, kd, ts, lim_lo, lim_hi;
    longint target, integ, last_err, last_out;
    bit     clear_armed;

    logic signed [DATA_W-1:0] expected_actuator[$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;
    int  quiet_cycles = 0;
    int  stall_left = 0;

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // floor(a*b / 2^16) with a limited to 48 bits
    function automatic longint qmul(longint a, longint b);
        longint hi, lo;
        a = clip(a, ACC_LO, ACC_HI);
        hi = a >>> 16;
        lo = a - hi * 65536;
        return hi * b + ((lo * b) >>> 16);
    endfunction

    function automatic longint qmul_lim(longint a, longint b);
        return clip(qmul(a, b), -PROD_LIM, PROD_LIM);
    endfunction

    function automatic longint pid_terms(longint e, bit with_d);
        longint s;
        s = qmul_lim(e, kp) + qmul_lim(integ, ki);
        if (with_d)
            s += qmul_lim(e - last_err, kd);
        return s;
    endfunction

    function automatic void limit_windup(longint s);
        if (aw_mode == AW_RESET) begin
            if (s >= lim_hi || s <= lim_lo)
                integ = 0;
        end else if (aw_mode == AW_BACK) begin
            if (s >= lim_hi) begin
                integ = clip(integ + (lim_hi - s), ACC_LO, ACC_HI);
                if (integ < 0) integ = 0;
            end else if (s <= lim_lo) begin
                integ = clip(integ + (lim_lo - s), ACC_LO, ACC_HI);
                if (integ > 0) integ = 0;
            end
        end
    endfunction

    function automatic longint regulate(longint meas);
        longint e, r, x;
        bit with_d;
        e = clip(target - meas, I32_MIN, I32_MAX);
        r = 0;
        if (ctl_type == CT_P) begin
            r = qmul_lim(e, kp);
        end else if (ctl_type == CT_PI || ctl_type == CT_PID) begin
            with_d = (ctl_type == CT_PID);
            integ = clip(integ + qmul(e, ts), ACC_LO, ACC_HI);
            limit_windup(pid_terms(e, with_d));
            r = pid_terms(e, with_d);
            if (with_d) last_err = e;
        end else if (ctl_type == CT_PT1) begin
            x = qmul_lim(e, longint'(PT1_GAIN)) - last_out;
            r = last_out + qmul_lim(x, longint'(PT1_TIME_FACTOR));
        end
        if (r > lim_hi) r = lim_hi;
        else if (r < lim_lo) r = lim_lo;
        return r;
    endfunction

    // returns 1 when the transaction yields an actuator value
    function automatic bit predict_actuator(logic [1:0] op, longint v, output longint act);
        act = 0;
        if (op == OP_SETPOINT) begin
            target = (ctl_type == CT_PT1) ?
                clip(qmul(v, longint'(SETPOINT_SCALE)), I32_MIN, I32_MAX) : v;
            return 1'b0;
        end
        if (op == OP_RESET) begin
            clear_armed = 1'b1;
            return 1'b0;
        end
        if (op != OP_MEASURE)
            return 1'b0;
        if (clear_armed) begin
            last_out = 0; integ = 0; last_err = 0; clear_armed = 1'b0;
        end
        if (target >= -1310 && target <= 1310) begin
            last_out = 0; integ = 0; last_err = 0;
        end else begin
            last_out = clip(qmul(regulate(v), longint'(OUTPUT_SCALE)), I32_MIN, I32_MAX);
        end
        act = last_out;
        return 1'b1;
    endfunction

    // result side: random backpressure, sometimes long, none while no_idle is set
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: stall_left <= $urandom_range(1, 3);
                3:       stall_left <= $urandom_range(10, 50);
                default: stall_left <= 0;
            endcase
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_actuator.size() == 0) begin
                $error("actuator_value: unexpected transaction, actual %0d", o_actuator_value);
                mismatches++;
            end else begin
                if (o_actuator_value !== expected_actuator[0]) begin
                    $error("actuator_value: expected %0d, actual %0d",
                           expected_actuator[0], o_actuator_value);
                    mismatches++;
                end
                void'(expected_actuator.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [31:0] v);
        int gap;
        longint act;
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                5:             gap = $urandom_range(8, 40);
                default:       gap = 0;
            endcase
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_sample_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_actuator(op, longint'(signed'(v)), act))
            expected_actuator.push_back(act[31:0]);
    endtask

    // pause the sender until every expected value has come, plus latency margin
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_actuator.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] ct, logic [1:0] aw, logic [31:0] p, logic [31:0] i,
                             logic [31:0] d, logic [31:0] t, logic [31:0] lo, logic [31:0] hi);
        logic [31:0] vals[8];
        vals = '{32'(ct), 32'(aw), p, i, d, t, lo, hi};
        for (int r = 0; r < 8; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= r[2:0];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        ctl_type = ct; aw_mode = aw;
        kp = longint'(signed'(p)); ki = longint'(signed'(i)); kd = longint'(signed'(d));
        ts = longint'(t[30:0]);
        lim_lo = longint'(signed'(lo)); lim_hi = longint'(signed'(hi));
    endtask

    function automatic logic [31:0] rand_q16;
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
            2:       return 32'(signed'($urandom_range(0, 2620)) - 1310);
            default: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    task automatic test_p_extremes;
        configure(CT_P, 2'd0, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'hFF9C_0000, 32'h0064_0000);
        send_item(OP_SETPOINT, 32'h000A_0000);
        send_item(OP_MEASURE, 32'h0000_0000);
        send_item(OP_MEASURE, 32'h7FFF_FFFF);
        send_item(OP_MEASURE, 32'h8000_0000);
        send_item(OP_UNUSED, 32'h1234_5678);
        send_item(OP_MEASURE, 32'hFFFF_FFFF);
        send_item(OP_SETPOINT, 32'd1310);
        send_item(OP_MEASURE, 32'h0001_0000);
        send_item(OP_SETPOINT, 32'd1311);
        send_item(OP_MEASURE, 32'h8000_0000);
        drain();
    endtask

    task automatic test_windup_modes;
        for (int aw = 0; aw < 4; aw++) begin
            configure(CT_PID, aw[1:0], 32'h0002_0000, 32'h0000_8000, 32'h0000_4000,
                      32'h7FFF_FFFF, 32'hFFF6_0000, 32'h000A_0000);
            send_item(OP_RESET, 0);
            send_item(OP_SETPOINT, 32'h0032_0000);
            send_item(OP_MEASURE, 32'h0000_0000);
            send_item(OP_MEASURE, 32'h0064_0000);
            send_item(OP_MEASURE, 32'h8000_0000);
            drain();
        end
    endtask

    task automatic test_pt1_and_unknown;
        configure(CT_PT1, AW_BACK, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_SETPOINT, 32'h7FFF_FFFF);
        send_item(OP_MEASURE, 32'h0001_0000);
        send_item(OP_MEASURE, 32'h8000_0000);
        send_item(OP_RESET, 32'hFFFF_FFFF);
        send_item(OP_MEASURE, 32'h0000_0000);
        drain();
        // inverted limits, then an unknown controller type
        configure(CT_PI, AW_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                  32'h0010_0000, 32'hFFF0_0000);
        send_item(OP_SETPOINT, 32'h8000_0000);
        send_item(OP_MEASURE, 32'h7FFF_FFFF);
        send_item(OP_MEASURE, 32'h0000_0000);
        drain();
        configure(3'd7, 2'd1, 0, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000);
        send_item(OP_MEASURE, 32'h0000_0000);
        drain();
    endtask

    task automatic test_random;
        logic [2:0] ct;
        logic [31:0] lo, hi;
        for (int ph = 0; ph < 12; ph++) begin
            ct = 3'($urandom_range(0, 5));
            if (ph < 8) ct = CT_P + 3'(ph % 4);
            if ($urandom_range(0, 3) == 0) begin
                lo = $urandom(); hi = $urandom();
            end else begin
                lo = 32'(-signed'($urandom_range(0, 1 << 24)));
                hi = 32'($urandom_range(0, 1 << 24));
            end
            if ($urandom_range(0, 3) == 0)
                configure(ct, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                          lo, hi);
            else
                configure(ct, 2'($urandom()), $urandom_range(0, 1 << 18),
                          $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 15),
                          $urandom_range(0, 1 << 17), lo, hi);
            no_idle = (ph % 5 == 2);
            send_item(OP_SETPOINT, rand_q16());
            for (int n = 0; n < 55; n++) begin
                case ($urandom_range(0, 19))
                    0, 1:    send_item(OP_SETPOINT, rand_q16());
                    2:       send_item(OP_RESET, $urandom());
                    3:       send_item(OP_UNUSED, $urandom());
                    default: send_item(OP_MEASURE, rand_q16());
                endcase
                if (n == 30 && ph == 4) begin
                    drain();
                end
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        ctl_type = 3'd0; aw_mode = 2'd0;
        kp = 0; ki = 0; kd = 0; ts = 65536; lim_lo = -6553600; lim_hi = 6553600;
        target = 0; integ = 0; last_err = 0; last_out = 0; clear_armed = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset defaults first, before any register write
        send_item(OP_SETPOINT, 32'h0032_0000);
        send_item(OP_MEASURE, 32'h0010_0000);
        drain();
        test_p_extremes();
        test_windup_modes();
        test_pt1_and_unknown();
        test_random();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
design/pspc_pkg.sv
design/pspc_ctrl.sv
design/pspc_dp.sv
design/pid_pt1_speed_controller_unit.sv
sim/testbench.sv
